>>> rtl/double_ended_queue_defines.svh
// ----------------------------------------------------------------------------
// double_ended_queue_defines
// assertion macros used by the queue control module
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define DQ_CHECK(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// consequence checked in the cycle after the trigger
`define DQ_CHECK_NEXT(name, trig, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// types and constants shared by the double-ended queue modules
// ----------------------------------------------------------------------------
package dq_pkg;

	localparam int DEPTH  = 16;
	localparam int SLOT_W = $clog2(DEPTH);
	localparam int WORD_W = 32;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic signed [WORD_W-1:0] word_t;

	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_REAR  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_REAR   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// per-cell controls
	typedef struct packed {
		logic shift;
		logic load;
		logic sel;
	} cell_ctl_t;

	// outcome of the current command
	typedef struct packed {
		status_t status;
		logic    pop_ok;
	} res_info_t;

endpackage

>>> rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// double-ended queue of signed 32-bit words held in a row of cells
// ----------------------------------------------------------------------------
// usage:
//   command channel: cmd_valid, cmd_stall, operation, push_value. a word is
//   taken at a clock edge with cmd_valid high and cmd_stall low. operation
//   selects push front, push rear, pop front or pop rear.
//   result channel: res_valid, res_stall, pop_value, status. exactly one
//   result word per command, in command order.
//   result: registered, it appears in the cycle after its command is taken.
//   throughput: one command per cycle while cmd_stall is low; the whole
//   decision, including the one-slot shift of every cell on a front push at
//   slot 0, completes in the cycle the command is taken.
//   stall: while a result is held and res_stall is high, cmd_stall is raised
//   and the held result stays unchanged.
//   reset: arst_n clears the queue to empty and drops any pending result;
//   stored words are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module double_ended_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [1:0]  operation,
	input  logic signed [31:0] push_value,
	output logic        res_valid,
	input  logic        res_stall,
	output logic signed [31:0] pop_value,
	output logic [1:0]  status
);

	dq_pkg::cell_ctl_t cell_ctl  [dq_pkg::DEPTH];
	dq_pkg::word_t     cell_word [dq_pkg::DEPTH];
	dq_pkg::word_t     rd_word   [dq_pkg::DEPTH];
	dq_pkg::res_info_t info;
	dq_pkg::word_t     rd_bus;
	dq_pkg::word_t     pop_value_d;
	logic              fire;
	logic              res_valid_q;
	dq_pkg::word_t     pop_value_q;
	dq_pkg::status_t   status_q;

	assign cmd_stall = res_valid_q && res_stall;
	assign fire      = cmd_valid && !cmd_stall;

	dq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.op       (dq_pkg::op_t'(operation)),
		.cell_ctl (cell_ctl),
		.info     (info)
	);

	for (genvar i = 0; i < dq_pkg::DEPTH; i++) begin : g_cell
		dq_pkg::word_t prev_word;
		if (i == 0) begin : g_bottom
			assign prev_word = '0;
		end else begin : g_link
			assign prev_word = cell_word[i-1];
		end
		dq_cell u_cell (
			.clk        (clk),
			.ctl        (cell_ctl[i]),
			.push_value (push_value),
			.prev_word  (prev_word),
			.word       (cell_word[i]),
			.rd_word    (rd_word[i])
		);
	end

	always_comb begin
		rd_bus = '0;
		for (int i = 0; i < dq_pkg::DEPTH; i++) begin
			rd_bus = rd_bus | rd_word[i];
		end
		if (info.status == dq_pkg::ST_EMPTY) begin
			pop_value_d = '1;
		end else if (info.pop_ok) begin
			pop_value_d = rd_bus;
		end else begin
			pop_value_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			pop_value_q <= pop_value_d;
			status_q    <= info.status;
		end
	end

	assign res_valid = res_valid_q;
	assign pop_value = pop_value_q;
	assign status    = status_q;

endmodule

>>> rtl/dq_cell.sv
// ----------------------------------------------------------------------------
// dq_cell
// one storage slot of the queue: loads a pushed word, takes its lower
// neighbour's word on a shift, and drives its word onto the read bus
// ----------------------------------------------------------------------------
module dq_cell (
	input  logic              clk,
	input  dq_pkg::cell_ctl_t ctl,
	input  dq_pkg::word_t     push_value,
	input  dq_pkg::word_t     prev_word,
	output dq_pkg::word_t     word,
	output dq_pkg::word_t     rd_word
);

	dq_pkg::word_t word_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			word_q <= push_value;
		end else if (ctl.shift) begin
			word_q <= prev_word;
		end
	end

	assign word    = word_q;
	// zero unless selected, so the bus is a plain or
	assign rd_word = ctl.sel ? word_q : '0;

endmodule

>>> rtl/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl
// front and rear tracking for the queue; decodes each command into per-cell
// load, shift and select controls
// ----------------------------------------------------------------------------
`include "double_ended_queue_defines.svh"

module dq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  dq_pkg::op_t         op,
	output dq_pkg::cell_ctl_t   cell_ctl [dq_pkg::DEPTH],
	output dq_pkg::res_info_t   info
);

	localparam dq_pkg::slot_t LAST = dq_pkg::SLOT_W'(dq_pkg::DEPTH - 1);

	dq_pkg::slot_t            front_q;
	dq_pkg::slot_t            rear_q;
	logic                     empty_q;
	dq_pkg::slot_t            front_d;
	dq_pkg::slot_t            rear_d;
	logic                     empty_d;
	logic                     wr_en;
	dq_pkg::slot_t            wr_slot;
	logic                     shift;
	logic                     rd_en;
	dq_pkg::slot_t            rd_slot;
	logic [dq_pkg::DEPTH-1:0] load_vec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			rear_q  <= '0;
			empty_q <= 1'b1;
		end else if (fire) begin
			front_q <= front_d;
			rear_q  <= rear_d;
			empty_q <= empty_d;
		end
	end

	always_comb begin
		front_d     = front_q;
		rear_d      = rear_q;
		empty_d     = empty_q;
		wr_en       = 1'b0;
		wr_slot     = '0;
		shift       = 1'b0;
		rd_en       = 1'b0;
		rd_slot     = front_q;
		info.status = dq_pkg::ST_DONE;
		info.pop_ok = 1'b0;
		case (op)
			dq_pkg::OP_PUSH_FRONT: begin
				if (empty_q) begin
					wr_en   = 1'b1;
					empty_d = 1'b0;
					front_d = '0;
					rear_d  = '0;
				end else if (front_q != '0) begin
					wr_en   = 1'b1;
					wr_slot = front_q - 1'b1;
					front_d = front_q - 1'b1;
				end else if (rear_q == LAST) begin
					info.status = dq_pkg::ST_FULL;
				end else begin
					// whole run moves up one slot, new word lands at the bottom
					shift  = 1'b1;
					wr_en  = 1'b1;
					rear_d = rear_q + 1'b1;
				end
			end
			dq_pkg::OP_PUSH_REAR: begin
				if (empty_q) begin
					wr_en   = 1'b1;
					empty_d = 1'b0;
					front_d = '0;
					rear_d  = '0;
				end else if (rear_q == LAST) begin
					info.status = dq_pkg::ST_FULL;
				end else begin
					wr_en   = 1'b1;
					wr_slot = rear_q + 1'b1;
					rear_d  = rear_q + 1'b1;
				end
			end
			dq_pkg::OP_POP_FRONT: begin
				if (empty_q) begin
					info.status = dq_pkg::ST_EMPTY;
				end else begin
					rd_en       = 1'b1;
					rd_slot     = front_q;
					info.pop_ok = 1'b1;
					if (front_q == rear_q) begin
						empty_d = 1'b1;
						front_d = '0;
						rear_d  = '0;
					end else begin
						front_d = front_q + 1'b1;
					end
				end
			end
			dq_pkg::OP_POP_REAR: begin
				if (empty_q) begin
					info.status = dq_pkg::ST_EMPTY;
				end else begin
					rd_en       = 1'b1;
					rd_slot     = rear_q;
					info.pop_ok = 1'b1;
					if (front_q == rear_q) begin
						empty_d = 1'b1;
						front_d = '0;
						rear_d  = '0;
					end else begin
						rear_d = rear_q - 1'b1;
					end
				end
			end
			default: begin
				info.status = dq_pkg::ST_DONE;
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < dq_pkg::DEPTH; i++) begin
			load_vec[i]       = fire && wr_en && (wr_slot == dq_pkg::SLOT_W'(i));
			cell_ctl[i].load  = load_vec[i];
			cell_ctl[i].shift = fire && shift;
			cell_ctl[i].sel   = rd_en && (rd_slot == dq_pkg::SLOT_W'(i));
		end
	end

	`DQ_CHECK(a_empty_slots, empty_q |-> (front_q == '0 && rear_q == '0),
		"empty queue with nonzero slots")
	`DQ_CHECK(a_slot_order, !empty_q |-> (front_q <= rear_q), "front above rear")
	`DQ_CHECK(a_one_load, $onehot0(load_vec), "more than one cell loaded")
	`DQ_CHECK_NEXT(a_full_holds, fire && info.status == dq_pkg::ST_FULL,
		$stable(rear_q) && $stable(front_q) && !empty_q, "refused push moved state")
	`DQ_CHECK_NEXT(a_shift_rear, fire && shift, (rear_q == $past(rear_q) + 1'b1) && front_q == '0,
		"shift did not advance rear")

endmodule

>>> sim/double_ended_queue_checker.sv
// ----------------------------------------------------------------------------
// double_ended_queue_checker
// watches both channels of the double-ended queue, keeps its own copy of the
// slots and both ends, and compares each result word with the oldest one due
// ----------------------------------------------------------------------------
module double_ended_queue_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  logic               cmd_stall,
	input  logic [1:0]         operation,
	input  logic signed [31:0] push_value,
	input  logic               res_valid,
	input  logic               res_stall,
	input  logic signed [31:0] pop_value,
	input  logic [1:0]         status,
	output int                 fail_count,
	output int                 outstanding,
	output int                 results_checked,
	output int                 shifted_pushes,
	output int                 refused_pushes,
	output int                 empty_pops
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		dq_pkg::word_t   word;
		dq_pkg::status_t st;
	} dq_result_t;

	dq_pkg::word_t slots [dq_pkg::DEPTH];
	int            front_idx;
	int            rear_idx;
	bit            holds_none;
	dq_result_t    pending_results [$];

	initial begin
		fail_count      = 0;
		outstanding     = 0;
		results_checked = 0;
		shifted_pushes  = 0;
		refused_pushes  = 0;
		empty_pops      = 0;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t ns  mismatch: %s", $time, msg);
		fail_count++;
	endtask

	// applies one command to the local queue copy and returns its result word
	function automatic dq_result_t apply_command(input dq_pkg::op_t op,
			input dq_pkg::word_t v);
		dq_result_t r;
		r.word = '0;
		r.st   = dq_pkg::ST_DONE;
		if (op == dq_pkg::OP_PUSH_FRONT || op == dq_pkg::OP_PUSH_REAR) begin
			if (holds_none) begin
				front_idx  = 0;
				rear_idx   = 0;
				holds_none = 1'b0;
				slots[0]   = v;
			end else if (op == dq_pkg::OP_PUSH_REAR) begin
				if (rear_idx == dq_pkg::DEPTH - 1) begin
					r.st = dq_pkg::ST_FULL;
				end else begin
					rear_idx++;
					slots[rear_idx] = v;
				end
			end else if (front_idx != 0) begin
				front_idx--;
				slots[front_idx] = v;
			end else if (rear_idx == dq_pkg::DEPTH - 1) begin
				r.st = dq_pkg::ST_FULL;
			end else begin
				// front already at slot 0: move the run up one place
				for (int i = rear_idx + 1; i > 0; i--)
					slots[i] = slots[i-1];
				slots[0] = v;
				rear_idx++;
			end
		end else if (holds_none) begin
			r.word = -1;
			r.st   = dq_pkg::ST_EMPTY;
		end else begin
			r.word = (op == dq_pkg::OP_POP_FRONT) ? slots[front_idx] : slots[rear_idx];
			if (front_idx == rear_idx) begin
				holds_none = 1'b1;
				front_idx  = 0;
				rear_idx   = 0;
			end else if (op == dq_pkg::OP_POP_FRONT) begin
				front_idx++;
			end else begin
				rear_idx--;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		dq_result_t  want;
		dq_result_t  got;
		dq_pkg::op_t op;
		if (!arst_n) begin
			holds_none = 1'b1;
			front_idx  = 0;
			rear_idx   = 0;
			pending_results.delete();
			outstanding <= 0;
		end else begin
			// result first: it belongs to a command taken at an earlier edge
			if (res_valid && !res_stall) begin
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("result word %0d/%0d with nothing outstanding",
						pop_value, status));
				end else begin
					want = pending_results.pop_front();
					results_checked++;
					if (pop_value !== want.word)
						report_mismatch($sformatf("pop_value %0d, wanted %0d",
							pop_value, want.word));
					if (status !== want.st)
						report_mismatch($sformatf("status %0d, wanted %s",
							status, want.st.name()));
				end
			end
			if (cmd_valid && !cmd_stall) begin
				op = dq_pkg::op_t'(operation);
				if (op == dq_pkg::OP_PUSH_FRONT && !holds_none && front_idx == 0
						&& rear_idx < dq_pkg::DEPTH - 1)
					shifted_pushes++;
				got = apply_command(op, push_value);
				if (got.st == dq_pkg::ST_FULL)
					refused_pushes++;
				if (got.st == dq_pkg::ST_EMPTY)
					empty_pops++;
				pending_results.push_back(got);
			end
			outstanding <= pending_results.size();
		end
	end

endmodule

>>> sim/double_ended_queue_tb.sv
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// drives commands into the double-ended queue: a directed run through the
// empty, shift and full corners, then push-heavy, pop-heavy or balanced random
// bursts with random gaps and result stalls; checking lives in the checker
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               cmd_valid  = 1'b0;
	logic               cmd_stall;
	logic [1:0]         operation  = dq_pkg::OP_PUSH_FRONT;
	logic signed [31:0] push_value = '0;
	logic               res_valid;
	logic               res_stall  = 1'b0;
	logic signed [31:0] pop_value;
	logic [1:0]         status;

	bit calm = 1'b0;

	int fail_count;
	int outstanding;
	int results_checked;
	int shifted_pushes;
	int refused_pushes;
	int empty_pops;

	double_ended_queue u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.operation  (operation),
		.push_value (push_value),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.pop_value  (pop_value),
		.status     (status)
	);

	double_ended_queue_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (cmd_valid),
		.cmd_stall       (cmd_stall),
		.operation       (operation),
		.push_value      (push_value),
		.res_valid       (res_valid),
		.res_stall       (res_stall),
		.pop_value       (pop_value),
		.status          (status),
		.fail_count      (fail_count),
		.outstanding     (outstanding),
		.results_checked (results_checked),
		.shifted_pushes  (shifted_pushes),
		.refused_pushes  (refused_pushes),
		.empty_pops      (empty_pops)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side holds off at random, except in the calm stretch
	always @(posedge clk)
		res_stall <= !calm && ($urandom_range(99) < 22);

	initial begin
		#2_000_000;
		$display("double_ended_queue_tb: errors");
		$finish;
	end

	// offers one command word and returns at the edge that takes it
	task automatic send_word(input dq_pkg::op_t op, input dq_pkg::word_t v);
		while (!calm && $urandom_range(99) < 22) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid  <= 1'b1;
		operation  <= op;
		push_value <= v;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
	endtask

	function automatic dq_pkg::word_t pick_word();
		case ($urandom_range(9))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			2:       return '0;
			3:       return -1;
			4:       return $urandom_range(15);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int          burst_left;
		int          push_bias;
		int          front_bias;
		bit          is_push;
		bit          at_front;
		dq_pkg::op_t op;

		burst_left = 0;
		push_bias  = 50;
		front_bias = 50;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty pops, push into empty, shift at slot 0, push below the front,
		// pop of the only word
		send_word(dq_pkg::OP_POP_FRONT, 32'sh7fff_ffff);
		send_word(dq_pkg::OP_POP_REAR, 32'sh8000_0000);
		send_word(dq_pkg::OP_PUSH_FRONT, 32'sh8000_0000);
		send_word(dq_pkg::OP_PUSH_REAR, 32'sh7fff_ffff);
		send_word(dq_pkg::OP_PUSH_FRONT, '0);
		send_word(dq_pkg::OP_POP_FRONT, -1);
		send_word(dq_pkg::OP_POP_FRONT, '0);
		send_word(dq_pkg::OP_PUSH_FRONT, -1);
		send_word(dq_pkg::OP_POP_REAR, '0);
		send_word(dq_pkg::OP_POP_REAR, '0);
		// fill from the front so every shift length occurs, then both refusals
		repeat (dq_pkg::DEPTH)
			send_word(dq_pkg::OP_PUSH_FRONT, $urandom);
		send_word(dq_pkg::OP_PUSH_FRONT, $urandom);
		send_word(dq_pkg::OP_PUSH_REAR, $urandom);

		// bursts lean towards filling, draining or neither, and towards one end
		for (int n = 0; n < 1020; n++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(10, 60);
				case ($urandom_range(2))
					0:       push_bias = 15;
					1:       push_bias = 50;
					default: push_bias = 85;
				endcase
				front_bias = $urandom_range(10, 90);
			end
			burst_left--;
			calm     <= (n >= 450 && n < 600);
			is_push  = $urandom_range(99) < push_bias;
			at_front = $urandom_range(99) < front_bias;
			if (is_push)
				op = at_front ? dq_pkg::OP_PUSH_FRONT : dq_pkg::OP_PUSH_REAR;
			else
				op = at_front ? dq_pkg::OP_POP_FRONT : dq_pkg::OP_POP_REAR;
			send_word(op, pick_word());
		end

		cmd_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("summary: %0d result words checked, %0d shifting front pushes",
			results_checked, shifted_pushes);
		$display("summary: %0d pushes refused when full, %0d pops on an empty queue",
			refused_pushes, empty_pops);
		if (fail_count == 0)
			$display("double_ended_queue_tb: clean");
		else
			$display("double_ended_queue_tb: errors");
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl
rtl/dq_pkg.sv
rtl/dq_cell.sv
rtl/dq_ctrl.sv
rtl/double_ended_queue.sv
sim/double_ended_queue_checker.sv
sim/double_ended_queue_tb.sv
